>>> design/grayscale_frame_rotate_negate_macros.svh
// ----------------------------------------------------------------------------
// grayscale_frame_rotate_negate assertion macros
// shared concurrent assertion forms, clocked on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef GRAYSCALE_FRAME_ROTATE_NEGATE_MACROS_SVH
`define GRAYSCALE_FRAME_ROTATE_NEGATE_MACROS_SVH

// same-cycle implication
`define GFRN_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GFRN_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/gfrn_pkg.sv
// ----------------------------------------------------------------------------
// gfrn_pkg
// shared types, codes and defaults of the grayscale frame rotate/negate block
// ----------------------------------------------------------------------------
`default_nettype none

package gfrn_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_PIXEL_BITS = 16;

  // port field widths
  localparam int DATA_BITS     = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_DIM_BITS  = 9;
  localparam int LEVEL_BITS    = 16;
  localparam int XFORM_BITS    = 2;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_LEVEL    = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TRANSFORM    = 2'd3;

  // transform codes
  localparam logic [XFORM_BITS-1:0] XF_NONE      = 2'd0;
  localparam logic [XFORM_BITS-1:0] XF_NEGATE    = 2'd1;
  localparam logic [XFORM_BITS-1:0] XF_ROT_RIGHT = 2'd2;
  localparam logic [XFORM_BITS-1:0] XF_ROT_LEFT  = 2'd3;

  // item kinds
  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  // register reset values
  localparam logic [CFG_DIM_BITS-1:0] RST_FRAME_WIDTH  = 9'd256;
  localparam logic [CFG_DIM_BITS-1:0] RST_FRAME_HEIGHT = 9'd256;
  localparam logic [LEVEL_BITS-1:0]   RST_MAX_LEVEL    = 16'd255;
  localparam logic [XFORM_BITS-1:0]   RST_TRANSFORM    = XF_NONE;

  // controller to datapath
  typedef struct packed {
    logic take;  // latch the accepted word
    logic calc;  // frame size, output position, coordinates
    logic step;  // store write or read address
    logic read;  // frame store read
    logic emit;  // load the output register
  } gfrn_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fetch;
  } gfrn_sts_t;

endpackage

`default_nettype wire

>>> design/gfrn_ctrl.sv
// ----------------------------------------------------------------------------
// gfrn_ctrl
// sequencer for one word at a time, plus output word valid
// ----------------------------------------------------------------------------
`default_nettype none

`include "grayscale_frame_rotate_negate_macros.svh"

module gfrn_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  input  wire gfrn_pkg::gfrn_sts_t  sts,
  output gfrn_pkg::gfrn_cmd_t       cmd
);
  import gfrn_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SIZE = 3'd1;
  localparam logic [2:0] ST_ADDR = 3'd2;
  localparam logic [2:0] ST_READ = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd.take = in_tvalid && in_tready;
    cmd.calc = (state_r == ST_SIZE);
    cmd.step = (state_r == ST_ADDR);
    cmd.read = (state_r == ST_READ);
    cmd.emit = (state_r == ST_DONE) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_SIZE;
      ST_SIZE: state_nxt = ST_ADDR;
      ST_ADDR: state_nxt = sts.fetch ? ST_READ : ST_IDLE;
      ST_READ: state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `GFRN_ASSERT_NEXT(a_accept_starts, in_tvalid && in_tready, state_r == ST_SIZE && !in_tready, "accepted word did not start work")
  `GFRN_ASSERT_NEXT(a_store_no_result, state_r == ST_ADDR && !sts.fetch, state_r == ST_IDLE && !cmd.emit, "store word went on toward a result")
  `GFRN_ASSERT_NEXT(a_read_then_done, state_r == ST_READ, state_r == ST_DONE, "read not followed by result stage")
  `GFRN_ASSERT_NEXT(a_done_fills_free, state_r == ST_DONE && !out_valid_r, out_valid_r, "result not loaded into free output register")

endmodule

`default_nettype wire

>>> design/gfrn_dp.sv
// ----------------------------------------------------------------------------
// gfrn_dp
// config registers, frame store, position counters and pixel transform
// ----------------------------------------------------------------------------
`default_nettype none

module gfrn_dp #(
  parameter int MAX_WIDTH  = gfrn_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gfrn_pkg::DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = gfrn_pkg::DEF_PIXEL_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_valid,
  input  wire logic [gfrn_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [gfrn_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  wire logic                               in_tuser,
  input  wire logic [gfrn_pkg::DATA_BITS-1:0]     in_tdata,
  input  wire gfrn_pkg::gfrn_cmd_t                cmd,
  output gfrn_pkg::gfrn_sts_t                     sts,
  output logic [gfrn_pkg::DATA_BITS-1:0]          out_tdata,
  output logic                                    out_tlast
);
  import gfrn_pkg::*;

  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int CMP_W   = (DIM_W > CFG_DIM_BITS) ? DIM_W : CFG_DIM_BITS;
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int TOT_W   = $clog2(DEPTH + 1);
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [LEVEL_BITS-1:0] PIX_MAX = LEVEL_BITS'((32'd1 << PIXEL_BITS) - 32'd1);

  // config registers
  logic [CFG_DIM_BITS-1:0] width_r, height_r;
  logic [LEVEL_BITS-1:0]   level_r;
  logic [XFORM_BITS-1:0]   xform_r;

  // accepted word
  logic                  func_r;
  logic [PIXEL_BITS-1:0] pix_r;

  // counters
  logic [DIM_W-1:0] out_row_r, out_row_nxt, out_col_r, out_col_nxt;
  logic [TOT_W-1:0] store_idx_r, store_idx_nxt;

  // pipeline registers
  logic [TOT_W-1:0]      total_r;
  logic [DIM_W-1:0]      r_r, c_r;
  logic                  last_r;
  logic [TOT_W-1:0]      addr_r;
  logic [PIXEL_BITS-1:0] rd_r;
  logic [DATA_BITS-1:0]  pixel_out_r;
  logic                  last_out_r;

  logic [PIXEL_BITS-1:0] mem [DEPTH];

  logic [CMP_W-1:0] w_ext, h_ext;
  logic [DIM_W-1:0] weff, heff, ow, oh, row0, col0, r_c, c_c, col_inc, row_inc;
  logic             rotated, wrap, last_c;
  logic [TOT_W-1:0] store_cur, store_inc;
  logic [LEVEL_BITS-1:0] lvl, pix16, neg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_FRAME_WIDTH;
      height_r <= RST_FRAME_HEIGHT;
      level_r  <= RST_MAX_LEVEL;
      xform_r  <= RST_TRANSFORM;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  width_r  <= cfg_data[CFG_DIM_BITS-1:0];
        CFG_FRAME_HEIGHT: height_r <= cfg_data[CFG_DIM_BITS-1:0];
        CFG_MAX_LEVEL:    level_r  <= cfg_data[LEVEL_BITS-1:0];
        CFG_TRANSFORM:    xform_r  <= cfg_data[XFORM_BITS-1:0];
        default:          xform_r  <= xform_r;
      endcase
    end
  end

  // zero acts as one, oversize saturates
  always_comb begin
    w_ext = CMP_W'(width_r);
    h_ext = CMP_W'(height_r);
    if (w_ext == '0) begin
      weff = DIM_W'(1);
    end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
      weff = DIM_W'(MAX_WIDTH);
    end else begin
      weff = DIM_W'(w_ext);
    end
    if (h_ext == '0) begin
      heff = DIM_W'(1);
    end else if (h_ext > CMP_W'(MAX_HEIGHT)) begin
      heff = DIM_W'(MAX_HEIGHT);
    end else begin
      heff = DIM_W'(h_ext);
    end
  end

  // output frame position and source coordinates
  always_comb begin
    rotated = (xform_r == XF_ROT_RIGHT) || (xform_r == XF_ROT_LEFT);
    ow      = rotated ? heff : weff;
    oh      = rotated ? weff : heff;
    wrap    = (out_row_r >= oh) || (out_col_r >= ow);
    row0    = wrap ? '0 : out_row_r;
    col0    = wrap ? '0 : out_col_r;
    unique case (xform_r)
      XF_ROT_RIGHT: begin
        r_c = heff - DIM_W'(1) - col0;
        c_c = row0;
      end
      XF_ROT_LEFT: begin
        r_c = col0;
        c_c = weff - DIM_W'(1) - row0;
      end
      XF_NONE, XF_NEGATE: begin
        r_c = row0;
        c_c = col0;
      end
      default: begin
        r_c = row0;
        c_c = col0;
      end
    endcase
    last_c  = (row0 == oh - DIM_W'(1)) && (col0 == ow - DIM_W'(1));
    col_inc = col0 + DIM_W'(1);
    row_inc = row0 + DIM_W'(1);
    if (col_inc >= ow) begin
      out_col_nxt = '0;
      out_row_nxt = (row_inc >= oh) ? '0 : row_inc;
    end else begin
      out_col_nxt = col_inc;
      out_row_nxt = row0;
    end
  end

  // store position restarts when past the frame end
  always_comb begin
    store_cur     = (store_idx_r >= total_r) ? '0 : store_idx_r;
    store_inc     = store_cur + TOT_W'(1);
    store_idx_nxt = (store_inc >= total_r) ? '0 : store_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_row_r   <= '0;
      out_col_r   <= '0;
      store_idx_r <= '0;
    end else begin
      if (cmd.calc && func_r == FUNC_FETCH) begin
        out_row_r <= out_row_nxt;
        out_col_r <= out_col_nxt;
      end
      if (cmd.step && func_r == FUNC_STORE) begin
        store_idx_r <= store_idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      func_r <= in_tuser;
      pix_r  <= in_tdata[PIXEL_BITS-1:0];
    end
    if (cmd.calc) begin
      total_r <= TOT_W'(weff) * TOT_W'(heff);
      r_r     <= r_c;
      c_r     <= c_c;
      last_r  <= last_c;
    end
    if (cmd.step) begin
      addr_r <= TOT_W'(r_r) * TOT_W'(weff) + TOT_W'(c_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && func_r == FUNC_STORE) begin
      mem[store_cur[ADDR_W-1:0]] <= pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_r <= mem[addr_r[ADDR_W-1:0]];
    end
  end

  // negative, clamped at zero
  always_comb begin
    lvl   = (level_r > PIX_MAX) ? PIX_MAX : level_r;
    pix16 = LEVEL_BITS'(rd_r);
    neg   = (pix16 > lvl) ? '0 : lvl - pix16;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pixel_out_r <= (xform_r == XF_NEGATE) ? DATA_BITS'(neg) : DATA_BITS'(pix16);
      last_out_r  <= last_r;
    end
  end

  assign sts.fetch = (func_r == FUNC_FETCH);
  assign out_tdata = pixel_out_r;
  assign out_tlast = last_out_r;

endmodule

`default_nettype wire

>>> design/grayscale_frame_rotate_negate.sv
// ----------------------------------------------------------------------------
// grayscale_frame_rotate_negate
// one-frame grayscale store with unchanged, negative and rotated read-back
// ----------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  in_      in   in_tvalid/in_tready   tuser: func, tdata: pixel_in
//  out_     out  out_tvalid/out_tready tdata: pixel_out, tlast: last_of_frame
//  cfg_     in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
//  a store word runs size and write steps, a fetch word size, address
//  multiply, registered read, output load; one word is in work at a time
//  the output register holds a result while the next word is taken
//  synchronous reset clears counters and registers, the frame store is not
//  cleared and needs no clearing pass; cfg_ready is always high
// ----------------------------------------------------------------------------
`default_nettype none

module grayscale_frame_rotate_negate #(
  parameter int MAX_WIDTH  = gfrn_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gfrn_pkg::DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = gfrn_pkg::DEF_PIXEL_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [gfrn_pkg::DATA_BITS-1:0]     in_tdata,   // pixel_in
  input  wire logic                               in_tuser,   // func
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [gfrn_pkg::DATA_BITS-1:0]          out_tdata,  // pixel_out
  output logic                                    out_tlast,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [gfrn_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [gfrn_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import gfrn_pkg::*;

  gfrn_cmd_t cmd;
  gfrn_sts_t sts;

  assign cfg_ready = 1'b1;

  gfrn_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  gfrn_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

`default_nettype wire

>>> bench/tb_grayscale_frame_rotate_negate.sv
// ----------------------------------------------------------------------------
// tb_grayscale_frame_rotate_negate
// self-checking bench: drives store and fetch words, predicts each fetched
// pixel from a shadow frame store and compares it with the result stream
// ----------------------------------------------------------------------------
`default_nettype none

module tb_grayscale_frame_rotate_negate;
  timeunit 1ns;
  timeprecision 1ps;

  import gfrn_pkg::*;

  localparam int MAX_W      = DEF_MAX_WIDTH;
  localparam int MAX_H      = DEF_MAX_HEIGHT;
  localparam int STORE_SIZE = MAX_W * MAX_H;
  localparam int RAND_ITEMS = 1650;
  localparam int HOLD_LEN   = 400;

  typedef struct packed {
    logic [DATA_BITS-1:0] pixel;
    logic                 last;
  } frame_px_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [DATA_BITS-1:0]     in_tdata = '0;   // pixel_in
  logic                     in_tuser = 1'b0; // func
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [DATA_BITS-1:0]     out_tdata;       // pixel_out
  logic                     out_tlast;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // shadow of the block
  logic [DATA_BITS-1:0]    frame_mem [STORE_SIZE];
  bit                      frame_written [STORE_SIZE];
  logic [16:0]             wr_pos;
  logic [7:0]              rd_row;
  logic [7:0]              rd_col;
  logic [CFG_DIM_BITS-1:0] reg_width;
  logic [CFG_DIM_BITS-1:0] reg_height;
  logic [LEVEL_BITS-1:0]   reg_level;
  logic [XFORM_BITS-1:0]   reg_xform;

  frame_px_t px_expected[$];
  int        fail_count = 0;
  int        words_sent = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  bit        hold_rx = 1'b0;

  grayscale_frame_rotate_negate i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int eff_dim(logic [CFG_DIM_BITS-1:0] v, int limit);
    if (v == 0) return 1;
    return (int'(v) > limit) ? limit : int'(v);
  endfunction

  function automatic void frame_dims(output int w, output int h, output int ow,
                                     output int oh);
    bit rotated;
    w = eff_dim(reg_width, MAX_W);
    h = eff_dim(reg_height, MAX_H);
    rotated = (reg_xform == XF_ROT_RIGHT) || (reg_xform == XF_ROT_LEFT);
    ow = rotated ? h : w;
    oh = rotated ? w : h;
  endfunction

  // store address the next fetch reads, restart included
  function automatic int fetch_addr();
    int w, h, ow, oh, row, col, r, c;
    frame_dims(w, h, ow, oh);
    row = rd_row;
    col = rd_col;
    if (row >= oh || col >= ow) begin
      row = 0;
      col = 0;
    end
    case (reg_xform)
      XF_ROT_RIGHT: begin
        r = h - 1 - col;
        c = row;
      end
      XF_ROT_LEFT: begin
        r = col;
        c = w - 1 - row;
      end
      default: begin
        r = row;
        c = col;
      end
    endcase
    return r * w + c;
  endfunction

  function automatic void predict_store(logic [DATA_BITS-1:0] pix);
    int w, h, ow, oh, total, pos;
    frame_dims(w, h, ow, oh);
    total = w * h;
    pos = wr_pos;
    if (pos >= total) pos = 0;
    frame_mem[pos] = pix;
    frame_written[pos] = 1'b1;
    pos++;
    if (pos >= total) pos = 0;
    wr_pos = pos[16:0];
  endfunction

  function automatic frame_px_t predict_fetch();
    int w, h, ow, oh, addr, row, col;
    frame_px_t res;
    logic [DATA_BITS-1:0] pix;
    frame_dims(w, h, ow, oh);
    addr = fetch_addr();
    row = rd_row;
    col = rd_col;
    if (row >= oh || col >= ow) begin
      row = 0;
      col = 0;
    end
    pix = frame_mem[addr];
    if (reg_xform == XF_NEGATE) pix = (pix > reg_level) ? '0 : reg_level - pix;
    res.pixel = pix;
    res.last = (row == oh - 1) && (col == ow - 1);
    col++;
    if (col >= ow) begin
      col = 0;
      row++;
      if (row >= oh) row = 0;
    end
    rd_row = row[7:0];
    rd_col = col[7:0];
    return res;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic push_word(logic func, logic [DATA_BITS-1:0] pix);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (func == FUNC_FETCH) px_expected.push_back(predict_fetch());
    else predict_store(pix);
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= pix;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // a fetch that would read a never-written entry turns into a store
  task automatic push_mixed(int fetch_pct);
    logic func;
    func = ($urandom_range(99) < fetch_pct && frame_written[fetch_addr()]) ?
           FUNC_FETCH : FUNC_STORE;
    push_word(func, DATA_BITS'($urandom_range(16'hFFFF)));
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (px_expected.size() != 0) @(posedge clk);
    // a store word may still be in work
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FRAME_WIDTH:  reg_width = val[CFG_DIM_BITS-1:0];
      CFG_FRAME_HEIGHT: reg_height = val[CFG_DIM_BITS-1:0];
      CFG_MAX_LEVEL:    reg_level = val[LEVEL_BITS-1:0];
      CFG_TRANSFORM:    reg_xform = val[XFORM_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_frame_regs(int w, int h, int lvl, logic [XFORM_BITS-1:0] xf);
    wait_drain();
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_BITS'(w));
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_BITS'(h));
    write_reg(CFG_MAX_LEVEL, CFG_DATA_BITS'(lvl));
    write_reg(CFG_TRANSFORM, CFG_DATA_BITS'(xf));
    cfg_valid <= 1'b0;
  endtask

  task automatic fetch_n(int n);
    repeat (n) push_word(FUNC_FETCH, DATA_BITS'($urandom_range(16'hFFFF)));
  endtask

  task automatic set_idle_mode(int mode);
    case (mode)
      1: begin send_idle_pct = 70; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 70; end
      3: begin send_idle_pct = 19; stall_pct = 19; end
      default: begin send_idle_pct = 0; stall_pct = 0; end
    endcase
  endtask

  // ---------------------------------------------------------------- receiver

  always @(posedge clk) begin
    out_tready <= hold_rx ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    frame_px_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (px_expected.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected word, expected none, actual pixel %h last %b",
                 $time, out_tdata, out_tlast);
      end else begin
        want = px_expected.pop_front();
        if (out_tdata !== want.pixel) begin
          fail_count++;
          $display("%0t: pixel mismatch, expected %h, actual %h",
                   $time, want.pixel, out_tdata);
        end
        if (out_tlast !== want.last) begin
          fail_count++;
          $display("%0t: last flag mismatch, expected %b, actual %b",
                   $time, want.last, out_tlast);
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  function automatic logic [XFORM_BITS-1:0] XF_BITS_CAST(int v);
    return v[XFORM_BITS-1:0];
  endfunction

  // reset register values: full-size frame, first row only
  task automatic test_reset_values();
    push_word(FUNC_STORE, 16'h0000);
    push_word(FUNC_STORE, 16'hFFFF);
    fetch_n(2);
  endtask

  // all four transforms on a 2x2 frame, levels around the negative limit
  task automatic test_transforms();
    set_frame_regs(2, 2, 16'h1234, XF_NONE);
    push_word(FUNC_STORE, 16'h0000);
    push_word(FUNC_STORE, 16'hFFFF);
    push_word(FUNC_STORE, 16'h1234);
    push_word(FUNC_STORE, 16'h1235);
    // read position left over from the full-size frame restarts here
    fetch_n(4);
    for (int xf = XF_NEGATE; xf <= XF_ROT_LEFT; xf++) begin
      set_frame_regs(2, 2, 16'h1234, XF_BITS_CAST(xf));
      fetch_n(4);
    end
  endtask

  // zero width acts as one, oversize height saturates
  task automatic test_size_limits();
    set_frame_regs(0, 511, 16'hFFFF, XF_ROT_LEFT);
    push_word(FUNC_STORE, 16'hA5A5);
    push_word(FUNC_STORE, 16'h5A5A);
    fetch_n(2);
  endtask

  // long receiver hold while fetches keep coming, so the input stalls
  task automatic test_output_backpressure();
    set_idle_mode(0);
    set_frame_regs(4, 4, 16'h00FF, XF_ROT_RIGHT);
    repeat (16) push_word(FUNC_STORE, DATA_BITS'($urandom_range(16'hFFFF)));
    fork
      begin
        hold_rx = 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_rx = 1'b0;
      end
    join_none
    fetch_n(16);
    wait_drain();
  endtask

  function automatic int pick_dim();
    int k;
    k = $urandom_range(99);
    if (k < 6) return 0;
    if (k < 10) return $urandom_range(256, 511);
    if (k < 22) return $urandom_range(7, 20);
    return $urandom_range(1, 6);
  endfunction

  function automatic int pick_level();
    int k;
    k = $urandom_range(99);
    if (k < 15) return 0;
    if (k < 30) return 16'hFFFF;
    if (k < 45) return $urandom_range(1, 255);
    return $urandom_range(16'hFFFF);
  endfunction

  task automatic test_random_frames();
    int phase, w, h, total, start;
    phase = 0;
    start = words_sent;
    while (words_sent - start < RAND_ITEMS) begin
      set_idle_mode(phase % 5);
      w = pick_dim();
      h = pick_dim();
      if (eff_dim(CFG_DIM_BITS'(w), MAX_W) * eff_dim(CFG_DIM_BITS'(h), MAX_H) > 320) begin
        if (eff_dim(CFG_DIM_BITS'(w), MAX_W) > eff_dim(CFG_DIM_BITS'(h), MAX_H)) begin
          h = $urandom_range(0, 1);
        end else begin
          w = $urandom_range(0, 1);
        end
      end
      set_frame_regs(w, h, pick_level(), XF_BITS_CAST($urandom_range(3)));
      total = eff_dim(CFG_DIM_BITS'(w), MAX_W) * eff_dim(CFG_DIM_BITS'(h), MAX_H);
      if ($urandom_range(99) < 80) begin
        // whole frame written, then read back, at most three words past its end
        repeat (total) push_word(FUNC_STORE, DATA_BITS'($urandom_range(16'hFFFF)));
        fetch_n(total + $urandom_range(0, 3));
        repeat ($urandom_range(0, 12)) push_mixed(50);
      end else begin
        repeat (20) push_mixed(60);
      end
      phase++;
    end
  endtask

  initial begin
    wr_pos = '0;
    rd_row = '0;
    rd_col = '0;
    reg_width = RST_FRAME_WIDTH;
    reg_height = RST_FRAME_HEIGHT;
    reg_level = RST_MAX_LEVEL;
    reg_xform = RST_TRANSFORM;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_transforms();
    test_size_limits();
    test_output_backpressure();
    test_random_frames();

    set_idle_mode(0);
    wait_drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
